// File: rtl/core/rwde_pkg.sv
`timescale 1ns / 1ps
package rwde_pkg;

  localparam int MAX_RADIUS  = 32;
  localparam int HIST_DEPTH  = 2 * MAX_RADIUS;
  localparam int GROUP_LANES = 8;
  localparam int NUM_GROUPS  = HIST_DEPTH / GROUP_LANES;
  localparam int GRP_W       = $clog2(NUM_GROUPS);
  localparam int LANE_W      = $clog2(GROUP_LANES);
  localparam int AGE_W       = $clog2(HIST_DEPTH);
  localparam int POS_W       = 7;
  localparam logic [POS_W-1:0] POS_MAX = 7'd127;
  localparam int RAD_W       = 6;
  localparam int PSUM_W      = 12;
  localparam int MAG_W       = 13;

  // Register index of the radius register.
  localparam logic REG_RADIUS = 1'b0;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] edge_red;
    logic [7:0] edge_green;
    logic [7:0] edge_blue;
    logic       row_done;
    logic       last_of_run;
  } pix_out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // Window placement shared by all lanes for the current result.
  typedef struct packed {
    logic [AGE_W-1:0] k;
    logic [RAD_W-1:0] r;
    logic [POS_W-1:0] pos;
  } win_ctl_t;

  typedef struct packed {
    logic signed [PSUM_W-1:0] red;
    logic signed [PSUM_W-1:0] green;
    logic signed [PSUM_W-1:0] blue;
  } psum_t;

  typedef struct packed {
    logic [MAG_W-1:0] red;
    logic [MAG_W-1:0] green;
    logic [MAG_W-1:0] blue;
  } mag_t;

endpackage

// File: rtl/core/rwde_lane_group.sv
`timescale 1ns / 1ps
module rwde_lane_group (
  input  logic                                       clk,
  input  logic [rwde_pkg::GRP_W-1:0]                 grp,
  input  rwde_pkg::pixel_t [rwde_pkg::GROUP_LANES-1:0] pix,
  input  rwde_pkg::win_ctl_t                         ctl,
  output rwde_pkg::psum_t                            psum
);
  import rwde_pkg::*;

  psum_t psum_next;

  // Each lane adds its pixel to the right window, subtracts it for the left one.
  always_comb begin
    logic [AGE_W:0]          age;
    logic [AGE_W:0]          k7;
    logic [AGE_W:0]          r7;
    logic                    in_right;
    logic                    in_left;
    logic                    valid;
    logic signed [PSUM_W-1:0] vr;
    logic signed [PSUM_W-1:0] vg;
    logic signed [PSUM_W-1:0] vb;
    psum_next = '0;
    k7 = {1'b0, ctl.k};
    r7 = {1'b0, ctl.r};
    for (int j = 0; j < GROUP_LANES; j++) begin
      age      = {1'b0, grp, LANE_W'(j)};
      in_right = (age <= k7) && ((age + r7) > k7);
      in_left  = (age > k7) && (age <= (k7 + r7));
      valid    = (POS_W'(age) <= ctl.pos);
      vr = signed'({{(PSUM_W-8){1'b0}}, pix[j].red});
      vg = signed'({{(PSUM_W-8){1'b0}}, pix[j].green});
      vb = signed'({{(PSUM_W-8){1'b0}}, pix[j].blue});
      if (valid && in_right) begin
        psum_next.red   = psum_next.red + vr;
        psum_next.green = psum_next.green + vg;
        psum_next.blue  = psum_next.blue + vb;
      end else if (valid && in_left) begin
        psum_next.red   = psum_next.red - vr;
        psum_next.green = psum_next.green - vg;
        psum_next.blue  = psum_next.blue - vb;
      end
    end
  end

  always_ff @(posedge clk) begin
    psum <= psum_next;
  end

endmodule

// File: rtl/core/rwde_merge.sv
`timescale 1ns / 1ps
module rwde_merge (
  input  logic                                    clk,
  input  rwde_pkg::psum_t [rwde_pkg::NUM_GROUPS-1:0] parts,
  output rwde_pkg::mag_t                          mag
);
  import rwde_pkg::*;

  localparam int SUM_W = MAG_W + 2;

  mag_t mag_next;

  // Combine the group sums and clamp negative differences to zero.
  always_comb begin
    logic signed [SUM_W-1:0] sr;
    logic signed [SUM_W-1:0] sg;
    logic signed [SUM_W-1:0] sb;
    sr = '0;
    sg = '0;
    sb = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      sr = sr + SUM_W'(parts[g].red);
      sg = sg + SUM_W'(parts[g].green);
      sb = sb + SUM_W'(parts[g].blue);
    end
    mag_next.red   = (sr > 0) ? sr[MAG_W-1:0] : '0;
    mag_next.green = (sg > 0) ? sg[MAG_W-1:0] : '0;
    mag_next.blue  = (sb > 0) ? sb[MAG_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    mag <= mag_next;
  end

endmodule

// File: rtl/core/rwde_divider.sv
`timescale 1ns / 1ps
module rwde_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  rwde_pkg::mag_t             num,
  input  logic [rwde_pkg::RAD_W-1:0] den,
  output rwde_pkg::pixel_t           quo,
  output logic                       done
);
  import rwde_pkg::*;

  localparam int TRY_W = MAG_W + 1;

  logic [MAG_W-1:0] rem [3];
  logic [7:0]       q   [3];
  logic             sat [3];
  logic [RAD_W-1:0] den_r;
  logic [2:0]       cnt;
  logic             busy;

  // Restoring division, one quotient bit per cycle for all three channels.
  always_ff @(posedge clk) begin
    logic [MAG_W-1:0] nums [3];
    logic [TRY_W-1:0] trial;
    nums[0] = num.red;
    nums[1] = num.green;
    nums[2] = num.blue;
    trial = TRY_W'({den_r, 7'b0}) >> (3'd7 - cnt);
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= 3'd7;
        den_r <= den;
        for (int c = 0; c < 3; c++) begin
          rem[c] <= nums[c];
          q[c]   <= '0;
          sat[c] <= ({1'b0, nums[c]} >= TRY_W'({den, 8'b0}));
        end
      end else if (busy) begin
        for (int c = 0; c < 3; c++) begin
          if ({1'b0, rem[c]} >= trial) begin
            rem[c]    <= rem[c] - trial[MAG_W-1:0];
            q[c][cnt] <= 1'b1;
          end
        end
        cnt <= cnt - 3'd1;
        if (cnt == 3'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo.red   = sat[0] ? 8'hFF : q[0];
  assign quo.green = sat[1] ? 8'hFF : q[1];
  assign quo.blue  = sat[2] ? 8'hFF : q[2];

endmodule

// File: rtl/core/row_window_difference_edge_core.sv
`timescale 1ns / 1ps
// A pixel with no result leaves the sequencer idle; a result passes through
// the lane sums, merge, divider start, 8 divider steps, the done check and
// the output load. A pixel with results, also a row end with R pending
// pixels, holds the input until its last result is loaded, plus output stalls.
// Synchronous reset clears control, row position and output valid, and
// sets the radius to 1; pixel history is masked by row position.
module row_window_difference_edge_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  rwde_pkg::pix_in_t           in_pix,
  output logic                        out_valid,
  input  logic                        out_ready,
  output rwde_pkg::pix_out_t          out_pix,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import rwde_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LANES, S_MERGE, S_START, S_DIVIDE, S_EMIT
  } state_t;

  state_t                          state;
  logic [RAD_W-1:0]                radius;
  logic [POS_W-1:0]                row_pos;
  pixel_t [HIST_DEPTH-1:0]         hist;
  win_ctl_t                        ctl;
  logic                            flush;
  psum_t [NUM_GROUPS-1:0]          parts;
  mag_t                            mag;
  pixel_t                          quo;
  logic                            div_done;
  logic [RAD_W-1:0]                r_eff;
  logic [RAD_W-1:0]                r_m1;
  logic [AGE_W-1:0]                k_next;
  logic                            has_result;
  logic                            last_res;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RADIUS) ? {{(32-RAD_W){1'b0}}, radius} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RAD_W'(1);
    end else if (psel && penable && pwrite && (paddr[2] == REG_RADIUS)) begin
      radius <= pwdata[RAD_W-1:0];
    end
  end

  // Effective radius and the first window position for this request.
  always_comb begin
    if (radius == '0) begin
      r_eff = RAD_W'(1);
    end else if (radius > RAD_W'(MAX_RADIUS)) begin
      r_eff = RAD_W'(MAX_RADIUS);
    end else begin
      r_eff = radius;
    end
    r_m1 = r_eff - RAD_W'(1);
    if (in_pix.row_end && (row_pos < POS_W'(r_m1))) begin
      k_next = row_pos[AGE_W-1:0];
    end else begin
      k_next = r_m1[AGE_W-1:0];
    end
    has_result = in_pix.row_end || (row_pos >= POS_W'(r_m1));
  end

  assign in_ready = (state == S_IDLE);
  assign last_res = !flush || (ctl.k == '0);

  // Lanes: one group of eight history taps per instance.
  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_lane
    rwde_lane_group u_lane (
      .clk  (clk),
      .grp  (GRP_W'(g)),
      .pix  (hist[g*GROUP_LANES +: GROUP_LANES]),
      .ctl  (ctl),
      .psum (parts[g])
    );
  end

  rwde_merge u_merge (
    .clk   (clk),
    .parts (parts),
    .mag   (mag)
  );

  rwde_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_START),
    .num   (mag),
    .den   (ctl.r),
    .quo   (quo),
    .done  (div_done)
  );

  // Sequencer, history and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_pos   <= '0;
      out_valid <= 1'b0;
      flush     <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            hist    <= {hist[HIST_DEPTH-2:0],
                        {in_pix.red, in_pix.green, in_pix.blue}};
            ctl.k   <= k_next;
            ctl.r   <= r_eff;
            ctl.pos <= row_pos;
            flush   <= in_pix.row_end;
            if (in_pix.row_end) begin
              row_pos <= '0;
            end else if (row_pos < POS_MAX) begin
              row_pos <= row_pos + POS_W'(1);
            end
            if (has_result) begin
              state <= S_LANES;
            end
          end
        end
        S_LANES:  state <= S_MERGE;
        S_MERGE:  state <= S_START;
        S_START:  state <= S_DIVIDE;
        S_DIVIDE: begin
          if (div_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid           <= 1'b1;
            out_pix.edge_red    <= quo.red;
            out_pix.edge_green  <= quo.green;
            out_pix.edge_blue   <= quo.blue;
            out_pix.row_done    <= flush && (ctl.k == '0);
            out_pix.last_of_run <= last_res;
            if (last_res) begin
              state <= S_IDLE;
            end else begin
              ctl.k <= ctl.k - AGE_W'(1);
              state <= S_LANES;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: tb/sv/row_window_difference_edge_core_tb.sv
`timescale 1ns / 1ps
module row_window_difference_edge_core_tb;
  import rwde_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  pix_in_t in_pix = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pix_out_t out_pix;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  row_window_difference_edge_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_pix(in_pix),
    .out_valid(out_valid), .out_ready(out_ready), .out_pix(out_pix),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Pixels waiting to be offered and edge results waiting to arrive.
  pix_in_t pixel_queue[$];
  pix_out_t edge_queue[$];
  int mismatches = 0;
  int cycles = 0;
  bit no_idle = 1'b0;
  bit sender_hold = 1'b0;
  int long_stall_req = 0;
  int long_stall_seen = 0;
  int stall_left = 0;

  // Predictor state: mirror of the window history and row counters.
  pixel_t hist_mem[HIST_DEPTH];
  logic [POS_W-1:0] row_pos = '0;
  logic [RAD_W-1:0] radius_reg = 6'd1;

  task automatic report(input string what, input pix_out_t got, input pix_out_t want);
    $display("mismatch %s: got r=%0d g=%0d b=%0d done=%0b last=%0b,",
             what, got.edge_red, got.edge_green, got.edge_blue, got.row_done,
             got.last_of_run,
             " want r=%0d g=%0d b=%0d done=%0b last=%0b",
             want.edge_red, want.edge_green, want.edge_blue,
             want.row_done, want.last_of_run);
    mismatches++;
  endtask

  function automatic logic [7:0] edge_value(input int rs, input int ls, input int r);
    int q;
    q = (rs > ls) ? (rs - ls) / r : 0;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  // Push the edge result centered at history age k.
  task automatic push_edge(input int k, input int pos, input int r, input bit done);
    int rs[3];
    int ls[3];
    pix_out_t res;
    rs = '{0, 0, 0};
    ls = '{0, 0, 0};
    for (int a = k - r + 1; a <= k + r; a++) begin
      if (a >= 0 && a < HIST_DEPTH && a <= pos) begin
        if (a <= k) begin
          rs[0] += hist_mem[a].red; rs[1] += hist_mem[a].green; rs[2] += hist_mem[a].blue;
        end else begin
          ls[0] += hist_mem[a].red; ls[1] += hist_mem[a].green; ls[2] += hist_mem[a].blue;
        end
      end
    end
    res.edge_red = edge_value(rs[0], ls[0], r);
    res.edge_green = edge_value(rs[1], ls[1], r);
    res.edge_blue = edge_value(rs[2], ls[2], r);
    res.row_done = done;
    res.last_of_run = 1'b0;
    edge_queue.push_back(res);
  endtask

  // Advance the predictor by one accepted pixel.
  task automatic predict_edges(input pix_in_t p);
    int r;
    int pos;
    int k;
    bit any;
    r = (radius_reg == 0) ? 1 : (radius_reg > MAX_RADIUS) ? MAX_RADIUS : radius_reg;
    pos = row_pos;
    any = 1'b0;
    for (int a = HIST_DEPTH - 1; a > 0; a--) hist_mem[a] = hist_mem[a - 1];
    hist_mem[0] = '{red: p.red, green: p.green, blue: p.blue};
    if (p.row_end) begin
      k = (pos < r - 1) ? pos : r - 1;
      for (; k >= 0; k--) push_edge(k, pos, r, k == 0);
      any = 1'b1;
      row_pos = '0;
    end else begin
      if (pos >= r - 1) begin
        push_edge(r - 1, pos, r, 1'b0);
        any = 1'b1;
      end
      if (row_pos < POS_MAX) row_pos = row_pos + 1'b1;
    end
    if (any) edge_queue[$].last_of_run = 1'b1;
  endtask

  // Driver: offers queued pixels, idling at random.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_edges(in_pix);
      if (!in_valid || in_ready) begin
        if (pixel_queue.size() > 0 && !sender_hold &&
            (no_idle || $urandom_range(99) >= 35)) begin
          in_valid <= 1'b1;
          in_pix <= pixel_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result and drives the receiver stalls.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (edge_queue.size() == 0) begin
          report("unexpected result", out_pix, '0);
        end else begin
          pix_out_t want;
          want = edge_queue.pop_front();
          if (out_pix.edge_red !== want.edge_red ||
              out_pix.edge_green !== want.edge_green ||
              out_pix.edge_blue !== want.edge_blue ||
              out_pix.row_done !== want.row_done ||
              out_pix.last_of_run !== want.last_of_run)
            report("result", out_pix, want);
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (long_stall_seen != long_stall_req) begin
        long_stall_seen <= long_stall_req;
        stall_left <= 400;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || $urandom_range(99) >= 35;
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("row_window_difference_edge_core_tb failed");
      $finish;
    end
  end

  task automatic write_radius(input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(4 * REG_RADIUS); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    radius_reg = value[RAD_W-1:0];
  endtask

  // Wait until every pixel is taken and every result has arrived.
  task automatic drain;
    while (pixel_queue.size() > 0 || in_valid || edge_queue.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_pixel(input logic [7:0] r, g, b, input bit last);
    pixel_queue.push_back('{red: r, green: g, blue: b, row_end: last});
  endtask

  task automatic queue_random_row(input int len);
    for (int i = 0; i < len; i++)
      queue_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), i == len - 1);
  endtask

  task automatic random_rows(input int count, input int maxlen);
    for (int n = 0; n < count; n++) queue_random_row(int'($urandom_range(maxlen, 1)));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset radius, extremes, a single-pixel row and a three-pixel row.
    queue_pixel(8'd255, 8'd0, 8'd255, 1'b1);
    queue_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    queue_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    queue_pixel(8'd0, 8'd255, 8'd0, 1'b1);
    drain();

    // Directed: a row shorter than the radius and a step edge.
    write_radius(32'd4);
    queue_pixel(8'd200, 8'd10, 8'd99, 1'b0);
    queue_pixel(8'd1, 8'd255, 8'd128, 1'b1);
    for (int i = 0; i < 8; i++) queue_pixel(i < 4 ? 8'd0 : 8'd255, 8'd255, 8'd7, i == 7);
    drain();

    // Radius zero behaves as one; radius above the maximum behaves as the maximum.
    write_radius(32'd0);
    queue_random_row(3);
    drain();
    write_radius(32'd63);
    queue_random_row(5);
    drain();

    // Radius changed in the middle of a row.
    write_radius(32'd3);
    for (int i = 0; i < 5; i++) queue_pixel(8'($urandom_range(255)), 8'hAA, 8'h55, 1'b0);
    drain();
    write_radius(32'd6);
    queue_random_row(4);
    drain();

    // Random rows over a spread of radii, one phase without idling.
    write_radius(32'd1);
    no_idle = 1'b1;
    random_rows(6, 6);
    drain();
    no_idle = 1'b0;

    write_radius(32'd2);
    long_stall_req = 1;
    random_rows(6, 8);
    drain();

    // Sender pauses here until all results are in.
    sender_hold = 1'b1;
    drain();
    sender_hold = 1'b0;

    write_radius(32'd32);
    queue_random_row(40);
    queue_random_row(3);
    drain();

    // Long row saturating the row position.
    write_radius(32'd5);
    queue_random_row(140);
    drain();

    write_radius($urandom_range(8, 2));
    random_rows(3, 10);
    drain();

    if (mismatches == 0) begin
      $display("row_window_difference_edge_core_tb passed");
    end else begin
      $display("row_window_difference_edge_core_tb failed");
    end
    $finish;
  end

endmodule
